FILE: rtl/scpt_pkg.sv
// Shared types and constants of the skin column peak tracker.
package scpt_pkg;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int COL_AW   = $clog2(MAX_COLS);
	localparam int CNT_W    = $clog2(MAX_ROWS + 1);
	localparam int FW_W     = 11;
	localparam int PW_W     = 10;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 11;

	localparam logic [CFG_IW-1:0] CFG_RED_MIN       = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_GREEN_MIN     = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_BLUE_MIN      = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_SPREAD_MIN    = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_RED_GREEN_MIN = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH   = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_PADDLE_WIDTH  = 3'd6;

	typedef struct packed {
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [9:0]  column;
		logic        frame_end;
	} pix_t;

	typedef struct packed {
		logic [9:0]  peak_column;
		logic [10:0] peak_count;
		logic [9:0]  paddle_left;
	} res_t;

	typedef struct packed {
		logic [7:0]      red_min;
		logic [7:0]      green_min;
		logic [7:0]      blue_min;
		logic [7:0]      spread_min;
		logic [7:0]      red_green_min;
		logic [FW_W-1:0] frame_width;
		logic [PW_W-1:0] paddle_width;
	} cfg_t;

	typedef struct packed {
		logic              wr_en;
		logic [COL_AW-1:0] wr_addr;
		logic [CNT_W-1:0]  wr_data;
		logic              rd_en;
		logic [COL_AW-1:0] rd_addr;
	} mem_req_t;

endpackage

FILE: rtl/scpt_skin.sv
// Skin color classifier for one pixel against the threshold registers.
module scpt_skin (
	input  scpt_pkg::pix_t pix,
	input  scpt_pkg::cfg_t cfg,
	output logic           skin
);
	import scpt_pkg::*;

	logic [7:0] lo;
	logic       above_min;
	logic       red_top;
	logic [7:0] rg_diff;
	logic [7:0] spread;

	always_comb begin
		lo        = (pix.blue <= pix.green) ? pix.blue : pix.green;
		above_min = (pix.red > cfg.red_min) && (pix.green > cfg.green_min) &&
			(pix.blue > cfg.blue_min);
		red_top   = (pix.red > pix.green) && (pix.red > pix.blue);
		// Both differences are only used when red is the largest component.
		rg_diff   = pix.red - pix.green;
		spread    = pix.red - lo;
		skin      = above_min && red_top && (rg_diff > cfg.red_green_min) &&
			(spread > cfg.spread_min);
	end

endmodule

FILE: rtl/scpt_count_mem.sv
// Column count memory: one write port and one registered read port.
module scpt_count_mem (
	input  logic                            clk,
	input  scpt_pkg::mem_req_t              req,
	output logic [scpt_pkg::CNT_W-1:0]      rd_data
);
	import scpt_pkg::*;

	logic [CNT_W-1:0] mem_q [MAX_COLS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem_q[req.rd_addr];
		end
	end

endmodule

FILE: rtl/scpt_ctrl.sv
// Sequencer: reset clear, count update, column scan with clear, and paddle clamp.
module scpt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  scpt_pkg::pix_t            in_pix,
	input  logic                      in_skin,
	output logic                      in_stall,
	input  scpt_pkg::cfg_t            cfg,
	output scpt_pkg::mem_req_t        mem_req,
	input  logic [scpt_pkg::CNT_W-1:0] mem_rd_data,
	output logic                      res_valid,
	output scpt_pkg::res_t            res,
	input  logic                      res_take
);
	import scpt_pkg::*;

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_UPD    = 8'b0000_0100,
		ST_SCAN   = 8'b0000_1000,
		ST_DRAIN  = 8'b0001_0000,
		ST_CLAMP1 = 8'b0010_0000,
		ST_CLAMP2 = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} state_t;

	localparam logic [COL_AW-1:0] LAST_COL = COL_AW'(MAX_COLS - 1);

	state_t              state_q;
	logic [COL_AW-1:0]   cnt_q;
	logic                vld_s1;
	logic [COL_AW-1:0]   idx_s1;
	logic [COL_AW-1:0]   col_q;
	logic                inc_q;
	logic                last_q;
	logic [COL_AW-1:0]   best_col_q;
	logic [CNT_W-1:0]    best_cnt_q;
	logic signed [11:0]  left0_q;
	logic [9:0]          left_q;
	logic [FW_W-1:0]     fw;
	logic                accept;
	logic                take_best;
	logic signed [11:0]  left0;
	logic [11:0]         reach;
	logic [11:0]         alt;
	logic [9:0]          left_fin;

	assign fw       = (cfg.frame_width > FW_W'(MAX_COLS)) ? FW_W'(MAX_COLS) : cfg.frame_width;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	// The first scanned column is taken whenever it lies inside the frame; later ones only when strictly larger.
	assign take_best = vld_s1 && ({1'b0, idx_s1} < fw) &&
		((idx_s1 == '0) || (mem_rd_data > best_cnt_q));

	always_comb begin
		left0 = $signed({2'b00, best_col_q}) - $signed({3'b000, cfg.paddle_width[PW_W-1:1]});
		reach = {1'b0, left0_q[10:0]} + {2'b00, cfg.paddle_width};
		alt   = {1'b0, fw} - {2'b00, cfg.paddle_width} - 12'd1;
		if (fw == '0 || left0_q[11]) begin
			left_fin = '0;
		end else if (reach >= {1'b0, fw}) begin
			left_fin = alt[11] ? 10'd0 : alt[9:0];
		end else begin
			left_fin = left0_q[9:0];
		end
	end

	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = cnt_q;
			end
			ST_IDLE: begin
				mem_req.rd_en   = accept;
				mem_req.rd_addr = COL_AW'(in_pix.column);
			end
			ST_UPD: begin
				mem_req.wr_en   = inc_q && (mem_rd_data < CNT_W'(MAX_ROWS));
				mem_req.wr_addr = col_q;
				mem_req.wr_data = mem_rd_data + CNT_W'(1);
			end
			ST_SCAN: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = cnt_q;
				mem_req.wr_en   = vld_s1;
				mem_req.wr_addr = idx_s1;
			end
			ST_DRAIN: begin
				mem_req.wr_en   = vld_s1;
				mem_req.wr_addr = idx_s1;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + COL_AW'(1);
					if (cnt_q == LAST_COL) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					cnt_q   <= '0;
					state_q <= last_q ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + COL_AW'(1);
					if (cnt_q == LAST_COL) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CLAMP1;
				end
				ST_CLAMP1: begin
					state_q <= ST_CLAMP2;
				end
				ST_CLAMP2: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			col_q  <= COL_AW'(in_pix.column);
			inc_q  <= in_skin && ({1'b0, in_pix.column} < fw);
			last_q <= in_pix.frame_end;
		end
		if (state_q == ST_UPD) begin
			best_col_q <= '0;
			best_cnt_q <= '0;
		end
		if (take_best) begin
			best_col_q <= idx_s1;
			best_cnt_q <= mem_rd_data;
		end
		if (state_q == ST_CLAMP1) begin
			left0_q <= left0;
		end
		if (state_q == ST_CLAMP2) begin
			left_q <= left_fin;
		end
	end

	assign res_valid       = (state_q == ST_FINISH);
	assign res.peak_column = 10'(best_col_q);
	assign res.peak_count  = 11'(best_cnt_q);
	assign res.paddle_left = left_q;

endmodule

FILE: rtl/skin_column_peak_tracker_core.sv
// Top level of the skin column peak tracker: registers, datapath and output stage.
//
// The block takes BGR pixels in raster order, one transfer at a time, and counts the
// skin colored pixels of every column in a 1024 entry count memory. Each ordinary pixel
// occupies the block for its count update: the count memory is read in the cycle of the
// transfer and the incremented count is written back in the next one. The pixel that
// carries frame_end adds a sweep over all 1024 count entries (one read and one clearing
// write per cycle), then a drain state that completes the peak, the paddle clamp states
// and a finish state, before the next pixel can be taken; the result then moves to an
// output register, and the block takes no new pixel until that register is free to
// receive it. After reset the block clears the whole count memory with in_stall high;
// configuration writes are taken at any time. Registers should be written only while no
// pixel is in flight. Counts saturate at 1024, columns at or beyond the frame width are
// not counted, and a frame width above 1024 is treated as 1024.
module skin_column_peak_tracker_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  scpt_pkg::pix_t                in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output scpt_pkg::res_t                out_data,
	input  logic                          cfg_we,
	input  logic [scpt_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [scpt_pkg::CFG_DW-1:0]   cfg_data
);
	import scpt_pkg::*;

	cfg_t             cfg_q;
	logic             skin;
	mem_req_t         mem_req;
	logic [CNT_W-1:0] mem_rd_data;
	logic             res_valid;
	res_t             res;
	logic             res_take;
	logic             out_valid_q;
	res_t             out_data_q;

	// Register writes: an index outside the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_min       <= 8'd95;
			cfg_q.green_min     <= 8'd40;
			cfg_q.blue_min      <= 8'd20;
			cfg_q.spread_min    <= 8'd15;
			cfg_q.red_green_min <= 8'd15;
			cfg_q.frame_width   <= FW_W'(640);
			cfg_q.paddle_width  <= PW_W'(100);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RED_MIN:       cfg_q.red_min       <= cfg_data[7:0];
				CFG_GREEN_MIN:     cfg_q.green_min     <= cfg_data[7:0];
				CFG_BLUE_MIN:      cfg_q.blue_min      <= cfg_data[7:0];
				CFG_SPREAD_MIN:    cfg_q.spread_min    <= cfg_data[7:0];
				CFG_RED_GREEN_MIN: cfg_q.red_green_min <= cfg_data[7:0];
				CFG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data[FW_W-1:0];
				CFG_PADDLE_WIDTH:  cfg_q.paddle_width  <= cfg_data[PW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	scpt_skin u_skin (
		.pix  (in_data),
		.cfg  (cfg_q),
		.skin (skin)
	);

	scpt_count_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	scpt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_pix      (in_data),
		.in_skin     (skin),
		.in_stall    (in_stall),
		.cfg         (cfg_q),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (res_take)
	);

	// The output register takes a new result whenever it is empty or being emptied by a
	// transfer in the same cycle.
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: rtl/scpt_checker.sv
// Port level checks of the skin column peak tracker and their binding.
module scpt_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  scpt_pkg::pix_t in_data,
	input  logic           out_valid,
	input  logic           out_stall,
	input  scpt_pkg::res_t out_data
);
	import scpt_pkg::*;

	// A held result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Every pixel transfer is followed by a stall for the count write-back.
	a_busy_after_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("pixel taken during count update");

	// The paddle edge never lies right of the peak column.
	a_left_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.paddle_left <= out_data.peak_column)
		else $error("paddle edge right of peak column");

	// Column counts saturate at the row limit.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.peak_count <= 11'(MAX_ROWS))
		else $error("peak count above row limit");

endmodule

bind skin_column_peak_tracker_core scpt_checker u_scpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

FILE: bench/tb_top.sv
// Self-checking testbench for the skin column peak tracker core.
module tb_top;
	import scpt_pkg::*;

	// The run is cut off at this many cycles. A correct run takes a small fraction of it.
	localparam int RUN_LIMIT     = 10_000_000;
	// One frame end costs the core a full sweep of the count memory, so this hold-off
	// covers any work still under way after the last result has been taken.
	localparam int SETTLE_CYCLES = 1100;
	// Index with no register behind it; a write there must change nothing.
	localparam logic [CFG_IW-1:0] CFG_NO_REG = 3'd7;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	pix_t              in_data   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	res_t              out_data;
	logic              cfg_we    = 1'b0;
	logic [CFG_IW-1:0] cfg_index = CFG_RED_MIN;
	logic [CFG_DW-1:0] cfg_data  = '0;

	// Mirror of the register file and of the per-column skin counts.
	cfg_t        regs_m = {8'd95, 8'd40, 8'd20, 8'd15, 8'd15, 11'd640, 10'd100};
	int unsigned skin_count [MAX_COLS];

	pix_t pixel_q [$];   // pixels waiting to be offered to the core
	res_t peak_q [$];    // predicted frame results, oldest first
	res_t peak_want;

	bit gap_on   = 1'b0;  // sender inserts idle cycles between transfers
	bit stall_on = 1'b0;  // receiver stalls the result channel
	int gap_left   = 0;
	int stall_left = 0;
	int errors        = 0;
	int cycle_cnt     = 0;
	int pixel_items   = 0;
	int frames_queued = 0;

	skin_column_peak_tracker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Applies one accepted pixel to the mirrored counts. A pixel that ends the frame
	// also scans the columns in use, queues the peak it finds and clears every count.
	function automatic void track_pixel(input pix_t px);
		int unsigned r, g, b, lo, fw, best_col, best_cnt;
		int left;
		res_t peak;
		r = px.red;
		g = px.green;
		b = px.blue;
		lo = (b <= g) ? b : g;
		// Widths beyond the count memory are treated as the full memory.
		fw = (regs_m.frame_width > MAX_COLS) ? MAX_COLS : regs_m.frame_width;
		// Columns outside the frame are never counted, and a count stops at MAX_ROWS.
		if (px.column < fw && r > regs_m.red_min && g > regs_m.green_min
				&& b > regs_m.blue_min && r > g && r > b
				&& r - g > regs_m.red_green_min && r - lo > regs_m.spread_min
				&& skin_count[px.column] < MAX_ROWS)
			skin_count[px.column]++;
		if (!px.frame_end)
			return;
		best_col = 0;
		best_cnt = 0;
		left = 0;
		// With a zero frame width nothing is scanned and every field stays zero.
		if (fw > 0) begin
			best_cnt = skin_count[0];
			// Strictly greater keeps the first column of a tie.
			for (int i = 1; i < fw; i++) begin
				if (skin_count[i] > best_cnt) begin
					best_cnt = skin_count[i];
					best_col = i;
				end
			end
			// Center the paddle on the peak, then keep it inside the frame.
			left = int'(best_col) - int'(regs_m.paddle_width / 2);
			if (left < 0) begin
				left = 0;
			end else if (left + int'(regs_m.paddle_width) >= int'(fw)) begin
				left = int'(fw) - int'(regs_m.paddle_width) - 1;
				if (left < 0)
					left = 0;
			end
		end
		peak.peak_column = best_col[9:0];
		peak.peak_count  = best_cnt[10:0];
		peak.paddle_left = left[9:0];
		peak_q.push_back(peak);
		foreach (skin_count[i])
			skin_count[i] = 0;
	endfunction

	// Idle length between transfers or of a stall: mostly none, sometimes short,
	// now and then long.
	function automatic int pick_idle(input bit on);
		int roll;
		if (!on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic pix_t pixel_of(input int b, input int g, input int r, input int col,
			input bit last);
		pix_t px;
		px.blue      = b[7:0];
		px.green     = g[7:0];
		px.red       = r[7:0];
		px.column    = col[9:0];
		px.frame_end = last;
		return px;
	endfunction

	// Builds a pixel that passes every skin test under the current thresholds. With
	// near_miss set, red sits exactly on its tightest bound, so the pixel just fails.
	// Where the thresholds leave no room, the colors are random.
	function automatic pix_t skin_pixel(input int col, input bit near_miss);
		int gmin, bmin, g, b, lo, floor_r, r;
		pix_t px;
		px = pixel_of($urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), col, 1'b0);
		gmin = regs_m.green_min;
		bmin = regs_m.blue_min;
		if (gmin < 255 && bmin < 255) begin
			g = $urandom_range(gmin + 1, (gmin + 48 < 255) ? gmin + 48 : 255);
			b = $urandom_range(bmin + 1, (bmin + 48 < 255) ? bmin + 48 : 255);
			lo = (b < g) ? b : g;
			floor_r = regs_m.red_min;
			if (g + int'(regs_m.red_green_min) > floor_r)
				floor_r = g + int'(regs_m.red_green_min);
			if (b > floor_r)
				floor_r = b;
			if (lo + int'(regs_m.spread_min) > floor_r)
				floor_r = lo + int'(regs_m.spread_min);
			r = -1;
			if (near_miss && floor_r <= 255)
				r = floor_r;
			else if (!near_miss && floor_r < 255)
				r = $urandom_range(floor_r + 1, (floor_r + 40 < 255) ? floor_r + 40 : 255);
			if (r >= 0)
				px = pixel_of(b, g, r, col, 1'b0);
		end
		return px;
	endfunction

	// Threshold value: mostly moderate, sometimes an extreme, and now and then with
	// upper data bits set that an 8-bit register drops.
	function automatic int random_threshold();
		int roll, thr;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			thr = 0;
		else if (roll == 1)
			thr = 255;
		else
			thr = $urandom_range(0, 100);
		if ($urandom_range(0, 4) == 0)
			thr = thr | ($urandom_range(1, 7) << 8);
		return thr;
	endfunction

	// Driver. A pixel leaves the pending queue once the previous transfer is done and
	// any idle gap has run out; a stalled pixel is held unchanged. Prediction happens
	// at the edge that completes the transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				track_pixel(in_data);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pixel_q.size() > 0) begin
					in_valid <= 1'b1;
					in_data  <= pixel_q.pop_front();
					gap_left <= pick_idle(gap_on);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [10:0] want,
			input logic [10:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Monitor. Each result transfer is compared with the oldest prediction, and the
	// stall line is driven with random stretches independent of out_valid.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (peak_q.size() == 0) begin
					$display("%0t: result with nothing expected, column %0d count %0d left %0d",
						$time, out_data.peak_column, out_data.peak_count,
						out_data.paddle_left);
					errors++;
				end else begin
					peak_want = peak_q.pop_front();
					check_field("peak_column", peak_want.peak_column, out_data.peak_column);
					check_field("peak_count", peak_want.peak_count, out_data.peak_count);
					check_field("paddle_left", peak_want.paddle_left, out_data.paddle_left);
				end
			end
			if (stall_left > 0) begin
				out_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall  <= 1'b0;
				stall_left <= pick_idle(stall_on);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= RUN_LIMIT) begin
			$display("** skin_column_peak_tracker_core: FAILED **");
			$finish;
		end
	end

	// Register write: one cycle with the write enable high. The mirror follows the
	// register widths, so upper data bits of a narrow register are dropped.
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_RED_MIN:       regs_m.red_min       = val[7:0];
			CFG_GREEN_MIN:     regs_m.green_min     = val[7:0];
			CFG_BLUE_MIN:      regs_m.blue_min      = val[7:0];
			CFG_SPREAD_MIN:    regs_m.spread_min    = val[7:0];
			CFG_RED_GREEN_MIN: regs_m.red_green_min = val[7:0];
			CFG_FRAME_WIDTH:   regs_m.frame_width   = val[FW_W-1:0];
			CFG_PADDLE_WIDTH:  regs_m.paddle_width  = val[PW_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_regs(input int rmin, input int gmin, input int bmin,
			input int spread, input int rg, input int fw, input int pw);
		write_reg(CFG_RED_MIN, CFG_DW'(rmin));
		write_reg(CFG_GREEN_MIN, CFG_DW'(gmin));
		write_reg(CFG_BLUE_MIN, CFG_DW'(bmin));
		write_reg(CFG_SPREAD_MIN, CFG_DW'(spread));
		write_reg(CFG_RED_GREEN_MIN, CFG_DW'(rg));
		write_reg(CFG_FRAME_WIDTH, CFG_DW'(fw));
		write_reg(CFG_PADDLE_WIDTH, CFG_DW'(pw));
	endtask

	// Waits until every pending pixel has been transferred and every predicted result
	// has come back.
	task automatic drain();
		while (pixel_q.size() != 0 || in_valid || peak_q.size() != 0)
			@(posedge clk);
	endtask

	// Registers are written only after the drain and this further hold-off, which
	// serves as a margin after the last result.
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Queues one frame of random length. Most pixels are skin colored and land on one
	// hot column or elsewhere in the frame; the rest just miss a bound, are fully
	// random, or fall anywhere in the column range. With pause_mid set the sender
	// waits halfway through until every outstanding result is in.
	task automatic queue_frame(input int len, input bit pause_mid);
		int fw_use, hot, col, roll;
		pix_t px;
		fw_use = (regs_m.frame_width > MAX_COLS) ? MAX_COLS : regs_m.frame_width;
		hot = (fw_use > 0) ? $urandom_range(0, fw_use - 1) : 0;
		for (int k = 0; k < len; k++) begin
			if (pause_mid && k == len / 2)
				drain();
			roll = $urandom_range(0, 99);
			if (fw_use == 0 || roll >= 88)
				col = $urandom_range(0, 1023);
			else if (roll < 50)
				col = hot;
			else
				col = $urandom_range(0, fw_use - 1);
			roll = $urandom_range(0, 99);
			if (roll < 75)
				px = skin_pixel(col, 1'b0);
			else if (roll < 85)
				px = skin_pixel(col, 1'b1);
			else
				px = pixel_of($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), col, 1'b0);
			px.frame_end = (k == len - 1);
			pixel_q.push_back(px);
		end
		pixel_items += len;
		frames_queued++;
	endtask

	initial begin
		foreach (skin_count[i])
			skin_count[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames under the reset thresholds and a 640 column frame. The
		// first one has two hits on column 5, single hits elsewhere, pixels right on
		// the red and red-minus-green bounds, an all-ones pixel on column 1023 and an
		// all-zero one, and ends on a skin pixel outside the frame.
		pixel_q.push_back(pixel_of(30, 50, 200, 5, 1'b0));
		pixel_q.push_back(pixel_of(30, 50, 200, 5, 1'b0));
		pixel_q.push_back(pixel_of(25, 60, 180, 3, 1'b0));
		pixel_q.push_back(pixel_of(255, 255, 255, 1023, 1'b0));
		pixel_q.push_back(pixel_of(0, 0, 0, 0, 1'b0));
		pixel_q.push_back(pixel_of(21, 41, 96, 7, 1'b0));
		pixel_q.push_back(pixel_of(21, 41, 95, 7, 1'b0));
		pixel_q.push_back(pixel_of(30, 134, 150, 9, 1'b0));
		pixel_q.push_back(pixel_of(30, 135, 150, 9, 1'b0));
		pixel_q.push_back(pixel_of(30, 50, 200, 700, 1'b1));
		// Nothing counted: all columns tie at zero.
		pixel_q.push_back(pixel_of(0, 0, 0, 0, 1'b1));
		// Peak on the last column in use, so the paddle is pushed back inside.
		pixel_q.push_back(pixel_of(30, 50, 200, 639, 1'b0));
		pixel_q.push_back(pixel_of(30, 50, 200, 639, 1'b1));
		// A tie between columns 20 and 10 goes to the lower column.
		pixel_q.push_back(pixel_of(30, 50, 200, 20, 1'b0));
		pixel_q.push_back(pixel_of(30, 50, 200, 10, 1'b0));
		pixel_q.push_back(pixel_of(255, 255, 255, 1023, 1'b1));
		settle();

		// Zero frame width and zero paddle width; a write to the unused index must
		// leave everything as it is.
		program_regs(0, 0, 0, 0, 0, 0, 0);
		write_reg(CFG_NO_REG, 11'h7FF);
		pixel_q.push_back(pixel_of(1, 1, 3, 0, 1'b0));
		pixel_q.push_back(pixel_of(1, 1, 3, 0, 1'b1));
		settle();

		// Frame width above the count memory and the widest paddle.
		program_regs(0, 0, 0, 0, 0, 2047, 1023);
		pixel_q.push_back(pixel_of(1, 1, 3, 1023, 1'b0));
		pixel_q.push_back(pixel_of(1, 1, 3, 1023, 1'b1));
		pixel_q.push_back(pixel_of(2, 2, 200, 512, 1'b1));
		settle();

		// Highest thresholds: no pixel can pass.
		program_regs(255, 255, 255, 255, 255, 1024, 1);
		pixel_q.push_back(pixel_of(254, 254, 255, 100, 1'b0));
		pixel_q.push_back(pixel_of(200, 10, 255, 0, 1'b1));
		settle();

		// Saturation: more skin pixels on one column than the count can hold.
		program_regs(95, 40, 20, 15, 15, 1, 1);
		gap_on   = 1'b1;
		stall_on = 1'b1;
		for (int k = 0; k < 1030; k++)
			pixel_q.push_back(skin_pixel(0, 1'b0));
		pixel_q.push_back(pixel_of(30, 50, 200, 0, 1'b1));
		pixel_items += 1031;
		settle();

		// Random phases: fresh register settings, idling switched per phase, and a
		// few frames each. Some frames hold the sender halfway until all is drained.
		while (pixel_items < 1750 || frames_queued < 50) begin
			program_regs(random_threshold(), random_threshold(), random_threshold(),
				random_threshold(), random_threshold(), 0, 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: write_reg(CFG_FRAME_WIDTH, CFG_DW'($urandom_range(1, 16)));
				6:       write_reg(CFG_FRAME_WIDTH, CFG_DW'(MAX_COLS));
				7:       write_reg(CFG_FRAME_WIDTH, CFG_DW'($urandom_range(17, 1023)));
				8:       write_reg(CFG_FRAME_WIDTH, CFG_DW'($urandom_range(1025, 2047)));
				default: write_reg(CFG_FRAME_WIDTH, CFG_DW'(0));
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: write_reg(CFG_PADDLE_WIDTH, CFG_DW'($urandom_range(1, 12)));
				5, 6, 7: write_reg(CFG_PADDLE_WIDTH, CFG_DW'($urandom_range(0, 1023)));
				8:       write_reg(CFG_PADDLE_WIDTH, CFG_DW'(0));
				default: write_reg(CFG_PADDLE_WIDTH, CFG_DW'(1023));
			endcase
			gap_on   = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(2, 5))
				queue_frame($urandom_range(4, 24),
					frames_queued == 1 || $urandom_range(0, 9) == 0);
			settle();
		end

		// Nothing is left to send; give any missing result a bounded chance to show.
		for (int n = 0; n < 4000 && peak_q.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (peak_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, peak_q.size());
			errors += peak_q.size();
		end
		if (errors == 0)
			$display("** skin_column_peak_tracker_core: PASSED **");
		else
			$display("** skin_column_peak_tracker_core: FAILED **");
		$finish;
	end

endmodule
